@@ src/ptt_pkg.sv @@
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types and constants for the point-in-tetrahedron orientation test.
// ----------------------------------------------------------------------------
package ptt_pkg;

  // width of one coordinate field on the ports and in a corner register
  localparam int unsigned COORD_W = 16;
  // default coordinate width taken from each field
  localparam int unsigned COORD_BITS_DEF = 16;
  // corner register width: x, y, z packed
  localparam int unsigned CORNER_W = 3 * COORD_W;
  // number of corners and of determinants (tetra plus four replaced)
  localparam int unsigned NUM_CORNERS = 4;
  localparam int unsigned NUM_DET = 5;
  // configuration index width
  localparam int unsigned CFG_IDX_W = 2;
  // stream payload widths, padded to bytes
  localparam int unsigned IN_DATA_W = 48;
  localparam int unsigned OUT_DATA_W = 16;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CORNER_A = 2'd0,
    REG_CORNER_B = 2'd1,
    REG_CORNER_C = 2'd2,
    REG_CORNER_D = 2'd3
  } reg_idx_e;

  // load enables of the pipeline stages
  typedef struct packed {
    logic s1;  // differences
    logic s2;  // 2x2 products
    logic s3;  // triple products
    logic s4;  // determinant sign
    logic s5;  // result register
  } stage_en_t;

endpackage

@@ src/point_in_tetrahedron_test.sv @@
// ----------------------------------------------------------------------------
// point_in_tetrahedron_test
// Exact orientation test of query points against one configured tetrahedron.
// ----------------------------------------------------------------------------
// channel  | direction | handshake                   | payload
// s_axis   | in        | s_axis_tvalid/s_axis_tready | point x, y, z
// m_axis   | out       | m_axis_tvalid/m_axis_tready | inside, degenerate, masks
// cfg      | in        | cfg_we_i (no wait)          | corner a..d by index
//
// One item per cycle sustained while the output is not stalled; an accepted item
// is registered in order: differences, products, triple products, sign, result.
// Five determinant pipelines run side by side, one per determinant.
// Reset clears the stage valid bits and the corner registers.
// Each stage loads when it is empty or its successor moves, so bubbles close
// up and a stalled output still lets earlier stages fill.
// ----------------------------------------------------------------------------
module point_in_tetrahedron_test #(
  parameter int unsigned COORD_BITS = ptt_pkg::COORD_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [ptt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ptt_pkg::CORNER_W-1:0]   cfg_data_i,
  // query points
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // point_x [15:0], point_y [31:16], point_z [47:32]
  input  logic [ptt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // results
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // inside_res [0], degenerate [1], positive_mask [5:2], zero_mask [9:6], zero [15:10]
  output logic [ptt_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int unsigned Cb = (COORD_BITS > ptt_pkg::COORD_W) ? ptt_pkg::COORD_W :
                               ((COORD_BITS < 1) ? 1 : COORD_BITS);
  localparam int unsigned CW = ptt_pkg::COORD_W;

  logic [ptt_pkg::CORNER_W-1:0] corner_q [ptt_pkg::NUM_CORNERS];
  logic signed [Cb-1:0]         corner_pt [4][3];
  logic signed [Cb-1:0]         query_pt [3];
  logic signed [Cb-1:0]         det_pts [ptt_pkg::NUM_DET][4][3];
  logic [ptt_pkg::NUM_DET-1:0]  pos;
  logic [ptt_pkg::NUM_DET-1:0]  zero;
  logic [4:1]                   valid_q;
  logic                         out_valid_q;
  logic [5:1]                   rdy;
  ptt_pkg::stage_en_t           en;
  logic                         inside_res;
  logic                         degenerate;
  logic [3:0]                   positive_mask;
  logic [3:0]                   zero_mask;

  // corner registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < ptt_pkg::NUM_CORNERS; j++) begin
        corner_q[j] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (ptt_pkg::reg_idx_e'(cfg_idx_i))
        ptt_pkg::REG_CORNER_A: corner_q[0] <= cfg_data_i;
        ptt_pkg::REG_CORNER_B: corner_q[1] <= cfg_data_i;
        ptt_pkg::REG_CORNER_C: corner_q[2] <= cfg_data_i;
        ptt_pkg::REG_CORNER_D: corner_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // coordinates: low bits of each field, read as signed
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      query_pt[a] = s_axis_tdata[CW*a +: Cb];
      for (int j = 0; j < 4; j++) begin
        corner_pt[j][a] = corner_q[j][CW*a +: Cb];
      end
    end
  end

  // point sets: tetrahedron first, then the point in place of each corner
  always_comb begin
    for (int k = 0; k < ptt_pkg::NUM_DET; k++) begin
      for (int j = 0; j < 4; j++) begin
        for (int a = 0; a < 3; a++) begin
          det_pts[k][j][a] = (k != 0 && j == k - 1) ? query_pt[a] : corner_pt[j][a];
        end
      end
    end
  end

  // per-stage ready chain
  always_comb begin
    rdy[5] = !out_valid_q || m_axis_tready;
    rdy[4] = !valid_q[4] || rdy[5];
    rdy[3] = !valid_q[3] || rdy[4];
    rdy[2] = !valid_q[2] || rdy[3];
    rdy[1] = !valid_q[1] || rdy[2];
    en.s1 = rdy[1];
    en.s2 = rdy[2];
    en.s3 = rdy[3];
    en.s4 = rdy[4];
    en.s5 = rdy[5];
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (en.s1) valid_q[1] <= s_axis_tvalid;
      if (en.s2) valid_q[2] <= valid_q[1];
      if (en.s3) valid_q[3] <= valid_q[2];
      if (en.s4) valid_q[4] <= valid_q[3];
      if (en.s5) out_valid_q <= valid_q[4];
    end
  end

  // determinant pipelines
  for (genvar k = 0; k < ptt_pkg::NUM_DET; k++) begin : g_det
    ptt_orient #(
      .Cb (Cb)
    ) u_orient (
      .clk_i  (clk_i),
      .en_i   (en),
      .pts_i  (det_pts[k]),
      .pos_o  (pos[k]),
      .zero_o (zero[k])
    );
  end

  ptt_classify u_classify (
    .clk_i           (clk_i),
    .en_i            (en),
    .pos_i           (pos),
    .zero_i          (zero),
    .inside_res_o    (inside_res),
    .degenerate_o    (degenerate),
    .positive_mask_o (positive_mask),
    .zero_mask_o     (zero_mask)
  );

  assign s_axis_tready = rdy[1];
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, zero_mask, positive_mask, degenerate, inside_res};

  // a degenerate tetrahedron never reports inside
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && degenerate |-> !inside_res)
    else $error("inside reported for degenerate tetrahedron");

  // a point inside lies on no face
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && inside_res |-> zero_mask == 4'd0)
    else $error("inside reported with a zero determinant");

  // input back-pressure only comes from a stalled, full output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready && (&valid_q))
    else $error("input stalled while the pipeline had room");

endmodule

@@ src/ptt_orient.sv @@
// ----------------------------------------------------------------------------
// ptt_orient
// Four-stage pipeline for one exact 4x4 orientation determinant; reports the
// sign of the determinant as positive and zero flags.
// ----------------------------------------------------------------------------
module ptt_orient #(
  parameter int unsigned Cb = ptt_pkg::COORD_BITS_DEF
) (
  input  logic                clk_i,
  input  ptt_pkg::stage_en_t  en_i,
  input  logic signed [Cb-1:0] pts_i [4][3],
  output logic                pos_o,
  output logic                zero_o
);

  localparam int unsigned DiffW  = Cb + 1;
  localparam int unsigned ProdW  = 2 * DiffW;
  localparam int unsigned MinorW = ProdW + 1;
  localparam int unsigned TripW  = DiffW + MinorW;
  localparam int unsigned DetW   = TripW + 2;

  logic signed [DiffW-1:0]  u_q [3];
  logic signed [DiffW-1:0]  v_q [3];
  logic signed [DiffW-1:0]  w_q [3];
  logic signed [DiffW-1:0]  u2_q [3];
  logic signed [ProdW-1:0]  prod_d [6];
  logic signed [ProdW-1:0]  prod_q [6];
  logic signed [MinorW-1:0] minor [3];
  logic signed [TripW-1:0]  trip_d [3];
  logic signed [TripW-1:0]  trip_q [3];
  logic signed [DetW-1:0]   d3;
  logic                     pos_q;
  logic                     zero_q;

  // stage 1: edge vectors from the first point
  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      for (int a = 0; a < 3; a++) begin
        u_q[a] <= DiffW'(pts_i[1][a]) - DiffW'(pts_i[0][a]);
        v_q[a] <= DiffW'(pts_i[2][a]) - DiffW'(pts_i[0][a]);
        w_q[a] <= DiffW'(pts_i[3][a]) - DiffW'(pts_i[0][a]);
      end
    end
  end

  // stage 2: products of the cofactor minors
  always_comb begin
    prod_d[0] = v_q[1] * w_q[2];
    prod_d[1] = v_q[2] * w_q[1];
    prod_d[2] = v_q[0] * w_q[2];
    prod_d[3] = v_q[2] * w_q[0];
    prod_d[4] = v_q[0] * w_q[1];
    prod_d[5] = v_q[1] * w_q[0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      prod_q <= prod_d;
      u2_q   <= u_q;
    end
  end

  // stage 3: minors times the first edge
  always_comb begin
    minor[0]  = MinorW'(prod_q[0]) - MinorW'(prod_q[1]);
    minor[1]  = MinorW'(prod_q[2]) - MinorW'(prod_q[3]);
    minor[2]  = MinorW'(prod_q[4]) - MinorW'(prod_q[5]);
    trip_d[0] = u2_q[0] * minor[0];
    trip_d[1] = u2_q[1] * minor[1];
    trip_d[2] = u2_q[2] * minor[2];
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      trip_q <= trip_d;
    end
  end

  // stage 4: sum and sign; the 4x4 determinant is the negated 3x3 one
  assign d3 = DetW'(trip_q[0]) - DetW'(trip_q[1]) + DetW'(trip_q[2]);

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      pos_q  <= d3[DetW-1];
      zero_q <= (d3 == '0);
    end
  end

  assign pos_o  = pos_q;
  assign zero_o = zero_q;

endmodule

@@ src/ptt_classify.sv @@
// ----------------------------------------------------------------------------
// ptt_classify
// Compares the replaced determinants against the tetrahedron's sign and
// holds the result item.
// ----------------------------------------------------------------------------
module ptt_classify (
  input  logic                                clk_i,
  input  ptt_pkg::stage_en_t                  en_i,
  input  logic [ptt_pkg::NUM_DET-1:0]         pos_i,   // bit 0 is the tetrahedron
  input  logic [ptt_pkg::NUM_DET-1:0]         zero_i,
  output logic                                inside_res_o,
  output logic                                degenerate_o,
  output logic [ptt_pkg::NUM_CORNERS-1:0]     positive_mask_o,
  output logic [ptt_pkg::NUM_CORNERS-1:0]     zero_mask_o
);

  logic [ptt_pkg::NUM_CORNERS-1:0] same;
  logic                            tet_neg;
  logic                            inside_q;
  logic                            degenerate_q;
  logic [ptt_pkg::NUM_CORNERS-1:0] pos_mask_q;
  logic [ptt_pkg::NUM_CORNERS-1:0] zero_mask_q;

  // sign agreement per replaced corner
  assign tet_neg = !pos_i[0] && !zero_i[0];

  always_comb begin
    for (int i = 0; i < ptt_pkg::NUM_CORNERS; i++) begin
      same[i] = (pos_i[0] && pos_i[i+1]) ||
                (tet_neg && !pos_i[i+1] && !zero_i[i+1]);
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (en_i.s5) begin
      inside_q     <= !zero_i[0] && (&same);
      degenerate_q <= zero_i[0];
      pos_mask_q   <= pos_i[ptt_pkg::NUM_DET-1:1];
      zero_mask_q  <= zero_i[ptt_pkg::NUM_DET-1:1];
    end
  end

  assign inside_res_o    = inside_q;
  assign degenerate_o    = degenerate_q;
  assign positive_mask_o = pos_mask_q;
  assign zero_mask_o     = zero_mask_q;

endmodule
